// ===== rtl/core/gbl_pkg.sv =====
package gbl_pkg;

    typedef enum logic [1:0]
    {
        JOB_ERR,
        JOB_HDR,
        JOB_ROW
    } job_kind_t;

    typedef struct packed
    {
        job_kind_t   kind;
        logic [1:0]  status;
        logic [15:0] x0;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] y1;
        logic [15:0] row_bits;
        logic [4:0]  width;
        logic [15:0] fg;
        logic [15:0] bg;
        logic        glyph_end;
    } job_t;

    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;
    localparam logic [7:0] ERR_BYTE  = 8'h00;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OOB      = 2'd1;
    localparam logic [1:0] STATUS_NO_GLYPH = 2'd2;

    localparam logic [5:0] STEP_CASET = 6'd0;
    localparam logic [5:0] STEP_X0_HI = 6'd1;
    localparam logic [5:0] STEP_X0_LO = 6'd2;
    localparam logic [5:0] STEP_X1_HI = 6'd3;
    localparam logic [5:0] STEP_X1_LO = 6'd4;
    localparam logic [5:0] STEP_RASET = 6'd5;
    localparam logic [5:0] STEP_Y0_HI = 6'd6;
    localparam logic [5:0] STEP_Y0_LO = 6'd7;
    localparam logic [5:0] STEP_Y1_HI = 6'd8;
    localparam logic [5:0] STEP_Y1_LO = 6'd9;
    localparam logic [5:0] STEP_RAMWR = 6'd10;
    localparam logic [5:0] STEP_PIXEL = 6'd11;

endpackage

// ===== rtl/core/glyph_blit_to_lcd_byte_stream_top.sv =====
// Glyph blitter: one monochrome bitmap row per request in, display-controller bytes out.
// Both sides look like a queue. A request is taken when push is high and full is low;
// a byte is taken when pop is high and empty is low, and the oldest byte stays on the
// result ports until then.
// The first row of a glyph checks the window and produces CASET, four bytes, RASET,
// four bytes and RAMWR, followed by its pixels. Every row produces two bytes per pixel,
// so a row gives 2 * width bytes, plus 11 bytes for the header row.
// A rejected window or a row without a glyph produces a single error byte, and the
// remaining rows of a rejected glyph produce nothing.
// The back-end byte sequencer gives one byte per cycle while jobs wait and pop stays high.
// A taken row request is written into the two-entry job queue; with the back end idle,
// the job moves to the current-job register and its first byte then to the output register.
// When the receiver stalls, the back end holds its byte and the job queue fills,
// after which full rises and the front end waits.
// Reset clears the glyph state, job queue and valid flags, not the output byte itself.
module glyph_blit_to_lcd_byte_stream_top #(
    parameter int SCREEN_WIDTH   = 320,
    parameter int SCREEN_HEIGHT  = 240,
    parameter int MAX_ROW_BITS   = 16,
    parameter int MAX_GLYPH_ROWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] row_bits,
    input  logic        first_row,
    input  logic [15:0] x_origin,
    input  logic [15:0] y_origin,
    input  logic [4:0]  glyph_width,
    input  logic [6:0]  glyph_height,
    input  logic [15:0] fg_color,
    input  logic [15:0] bg_color,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        is_data,
    output logic        last,
    output logic        glyph_end,
    output logic [1:0]  status
);
    import gbl_pkg::*;

    logic job_push;
    job_t job_in;
    job_t job_head;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign full = q_full;

    gbl_front #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .MAX_ROW_BITS   (MAX_ROW_BITS),
        .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (q_full),
        .row_bits     (row_bits),
        .first_row    (first_row),
        .x_origin     (x_origin),
        .y_origin     (y_origin),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .fg_color     (fg_color),
        .bg_color     (bg_color),
        .job_push     (job_push),
        .job          (job_in)
    );

    gbl_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .rd_en   (q_pop),
        .rd_job  (job_head),
        .q_full  (q_full),
        .q_valid (q_valid)
    );

    gbl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (job_head),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .is_data   (is_data),
        .last      (last),
        .glyph_end (glyph_end),
        .status    (status)
    );

endmodule

// ===== rtl/core/gbl_front.sv =====
module gbl_front #(
    parameter int SCREEN_WIDTH   = 320,
    parameter int SCREEN_HEIGHT  = 240,
    parameter int MAX_ROW_BITS   = 16,
    parameter int MAX_GLYPH_ROWS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          q_full,
    input  logic [15:0]   row_bits,
    input  logic          first_row,
    input  logic [15:0]   x_origin,
    input  logic [15:0]   y_origin,
    input  logic [4:0]    glyph_width,
    input  logic [6:0]    glyph_height,
    input  logic [15:0]   fg_color,
    input  logic [15:0]   bg_color,
    output logic          job_push,
    output gbl_pkg::job_t job
);
    import gbl_pkg::*;

    logic [6:0]  rows_left_reg, rows_left_next;
    logic [4:0]  active_width_reg, active_width_next;
    logic [15:0] active_fg_reg, active_fg_next;
    logic [15:0] active_bg_reg, active_bg_next;
    logic        dropping_reg, dropping_next;
    logic        accept;
    logic [17:0] x_end;
    logic [17:0] y_end;
    logic        window_ok;
    logic [6:0]  h_minus_one;

    assign accept      = push && !q_full;
    assign x_end       = {2'b00, x_origin} + {13'd0, glyph_width};
    assign y_end       = {2'b00, y_origin} + {11'd0, glyph_height};
    assign h_minus_one = glyph_height - 7'd1;
    assign window_ok   = (glyph_width != 5'd0) && (glyph_width <= 5'(MAX_ROW_BITS))
                      && (glyph_height != 7'd0) && (glyph_height <= 7'(MAX_GLYPH_ROWS))
                      && (x_end <= 18'(SCREEN_WIDTH)) && (y_end <= 18'(SCREEN_HEIGHT));

    always_comb
    begin
        rows_left_next    = rows_left_reg;
        active_width_next = active_width_reg;
        active_fg_next    = active_fg_reg;
        active_bg_next    = active_bg_reg;
        dropping_next     = dropping_reg;
        job_push          = 1'b0;
        job.kind          = JOB_ROW;
        job.status        = STATUS_OK;
        job.x0            = x_origin;
        job.x1            = x_origin + {11'd0, glyph_width} - 16'd1;
        job.y0            = y_origin;
        job.y1            = y_origin + {9'd0, glyph_height} - 16'd1;
        job.row_bits      = row_bits;
        job.width         = active_width_reg;
        job.fg            = active_fg_reg;
        job.bg            = active_bg_reg;
        job.glyph_end     = 1'b0;
        if (accept)
        begin
            if (first_row)
            begin
                job_push = 1'b1;
                if (!window_ok)
                begin
                    job.kind       = JOB_ERR;
                    job.status     = STATUS_OOB;
                    rows_left_next = (glyph_height != 7'd0) ? h_minus_one : 7'd0;
                    dropping_next  = (glyph_height != 7'd0) && (h_minus_one != 7'd0);
                end
                else
                begin
                    job.kind          = JOB_HDR;
                    job.width         = glyph_width;
                    job.fg            = fg_color;
                    job.bg            = bg_color;
                    job.glyph_end     = (h_minus_one == 7'd0);
                    active_width_next = glyph_width;
                    active_fg_next    = fg_color;
                    active_bg_next    = bg_color;
                    rows_left_next    = h_minus_one;
                    dropping_next     = 1'b0;
                end
            end
            else if (dropping_reg)
            begin
                if (rows_left_reg != 7'd0)
                begin
                    rows_left_next = rows_left_reg - 7'd1;
                end
                if (rows_left_next == 7'd0)
                begin
                    dropping_next = 1'b0;
                end
            end
            else if (rows_left_reg == 7'd0)
            begin
                job_push   = 1'b1;
                job.kind   = JOB_ERR;
                job.status = STATUS_NO_GLYPH;
            end
            else
            begin
                job_push       = 1'b1;
                job.glyph_end  = (rows_left_reg == 7'd1);
                rows_left_next = rows_left_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_left_reg    <= 7'd0;
            active_width_reg <= 5'd0;
            active_fg_reg    <= 16'd0;
            active_bg_reg    <= 16'd0;
            dropping_reg     <= 1'b0;
        end
        else
        begin
            rows_left_reg    <= rows_left_next;
            active_width_reg <= active_width_next;
            active_fg_reg    <= active_fg_next;
            active_bg_reg    <= active_bg_next;
            dropping_reg     <= dropping_next;
        end
    end

endmodule

// ===== rtl/core/gbl_jobq.sv =====
module gbl_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  gbl_pkg::job_t wr_job,
    input  logic          rd_en,
    output gbl_pkg::job_t rd_job,
    output logic          q_full,
    output logic          q_valid
);
    import gbl_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == (AW+1)'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/core/gbl_back.sv =====
module gbl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  gbl_pkg::job_t q_job,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    out_byte,
    output logic          is_data,
    output logic          last,
    output logic          glyph_end,
    output logic [1:0]    status
);
    import gbl_pkg::*;

    job_t        cur_reg, cur_next;
    logic        cur_valid_reg, cur_valid_next;
    logic [5:0]  step_reg, step_next;
    logic [5:0]  end_step_reg, end_step_next;
    logic [15:0] bits_reg, bits_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        is_data_reg;
    logic        last_reg;
    logic        glyph_end_reg;
    logic [1:0]  status_reg;

    logic        out_free;
    logic        emit;
    logic        cur_last;
    logic        load;
    logic [5:0]  pix_off;
    logic [15:0] color;
    logic [7:0]  sel_byte;
    logic        sel_data;

    assign out_free = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && out_free;
    assign cur_last = (cur_reg.kind == JOB_ERR) || (step_reg == end_step_reg);
    assign load     = q_valid && (!cur_valid_reg || (emit && cur_last));
    assign q_pop    = load;
    assign pix_off  = step_reg - STEP_PIXEL;
    assign color    = bits_reg[15] ? cur_reg.fg : cur_reg.bg;

    always_comb
    begin
        sel_byte = ERR_BYTE;
        sel_data = 1'b0;
        if (cur_reg.kind != JOB_ERR)
        begin
            case (step_reg)
                STEP_CASET: sel_byte = CMD_CASET;
                STEP_X0_HI: begin sel_byte = cur_reg.x0[15:8]; sel_data = 1'b1; end
                STEP_X0_LO: begin sel_byte = cur_reg.x0[7:0];  sel_data = 1'b1; end
                STEP_X1_HI: begin sel_byte = cur_reg.x1[15:8]; sel_data = 1'b1; end
                STEP_X1_LO: begin sel_byte = cur_reg.x1[7:0];  sel_data = 1'b1; end
                STEP_RASET: sel_byte = CMD_RASET;
                STEP_Y0_HI: begin sel_byte = cur_reg.y0[15:8]; sel_data = 1'b1; end
                STEP_Y0_LO: begin sel_byte = cur_reg.y0[7:0];  sel_data = 1'b1; end
                STEP_Y1_HI: begin sel_byte = cur_reg.y1[15:8]; sel_data = 1'b1; end
                STEP_Y1_LO: begin sel_byte = cur_reg.y1[7:0];  sel_data = 1'b1; end
                STEP_RAMWR: sel_byte = CMD_RAMWR;
                default:
                begin
                    sel_byte = pix_off[0] ? color[7:0] : color[15:8];
                    sel_data = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        end_step_next  = end_step_reg;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = step_reg + 6'd1;
            if ((step_reg >= STEP_PIXEL) && pix_off[0])
            begin
                bits_next = {bits_reg[14:0], 1'b0};
            end
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            cur_valid_next = 1'b1;
            cur_next       = q_job;
            step_next      = (q_job.kind == JOB_HDR) ? STEP_CASET : STEP_PIXEL;
            end_step_next  = STEP_PIXEL + {q_job.width, 1'b0} - 6'd1;
            bits_next      = q_job.row_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        step_reg     <= step_next;
        end_step_reg <= end_step_next;
        bits_reg     <= bits_next;
        if (emit)
        begin
            out_byte_reg  <= sel_byte;
            is_data_reg   <= sel_data;
            last_reg      <= cur_last;
            glyph_end_reg <= cur_last && cur_reg.glyph_end;
            status_reg    <= cur_reg.status;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;
    assign glyph_end = glyph_end_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/core/gbl_checker.sv =====
module gbl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       is_data,
    input logic       last,
    input logic       glyph_end,
    input logic [1:0] status
);
    import gbl_pkg::*;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != STATUS_OK)) |-> last)
        else $error("Error result is not the last byte of its request.");

    a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != STATUS_OK)) |-> ((out_byte == ERR_BYTE) && !is_data && !glyph_end))
        else $error("Error result carries a nonzero payload.");

    a_glyph_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && glyph_end) |-> (last && is_data))
        else $error("Glyph end is set on a byte that does not close a row.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
        else $error("Result changed while the receiver stalled.");

endmodule

bind glyph_blit_to_lcd_byte_stream_top gbl_checker u_gbl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last),
    .glyph_end (glyph_end),
    .status    (status)
);
